>>> rtl/rgb_min_max_contrast_stretch_top_defines.svh
// assertion macros for the contrast stretch top
`ifndef RGB_MIN_MAX_CONTRAST_STRETCH_TOP_DEFINES_SVH
`define RGB_MIN_MAX_CONTRAST_STRETCH_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RGBCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgbcs same-cycle check failed");

// next-cycle implication, disabled while in reset
`define RGBCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgbcs next-cycle check failed");

`endif

>>> rtl/rgbcs_pkg.sv
// shared types and constants for the rgb contrast stretch block
package rgbcs_pkg;

  localparam int PIX_W     = 8;
  localparam int KIND_W    = 2;
  localparam int DIV_STEPS = PIX_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [PIX_W-1:0] FULL_SCALE = '1;
  localparam logic [PIX_W-1:0] PIX_ZERO   = '0;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GATHER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MAP    = 2'd2;

  // control from the sequencer to every lane
  typedef struct packed {
    logic clear;
    logic gather;
    logic start;
    logic step;
  } lane_ctl_t;

  // what one lane hands to the merge stage
  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             flat;
  } lane_res_t;

endpackage

>>> rtl/rgb_min_max_contrast_stretch_top.sv
// rgb min/max contrast stretch: sequencer, three channel lanes and merge stage
//
// Input channel in_*: in_kind selects clear (reset statistics), gather (fold
// the pixel into the per-channel min/max) or map (stretch the pixel); kind 3
// is dropped. Clear and gather requests are taken one per clock while no
// map is in progress and give no output. A map request gives one output
// request on out_*. Each channel is a lane with its own bit-serial divider;
// the three run in lockstep and the merge stage sets out_stretch_skipped when
// all are flat. A map is set up at the accepting edge, then runs eight divider
// steps (one quotient bit each) and one load of the output register. in_stall
// is high from acceptance until that load, so no new request is taken before
// the last map is through.
// The output register holds its request while out_stall is high; a finished
// map then waits in the lanes and in_stall stays high until it can move.
// Clear and gather requests are still accepted while an output request waits.
// Synchronous reset sets every minimum to 255, every maximum to 0, and
// empties the output register.
`include "rgb_min_max_contrast_stretch_top_defines.svh"
module rgb_min_max_contrast_stretch_top import rgbcs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [PIX_W-1:0]  in_red_in,
  input  logic [PIX_W-1:0]  in_green_in,
  input  logic [PIX_W-1:0]  in_blue_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  out_red_out,
  output logic [PIX_W-1:0]  out_green_out,
  output logic [PIX_W-1:0]  out_blue_out,
  output logic              out_stretch_skipped
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DRAIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_acc;
  logic             out_free;
  logic             load;
  lane_ctl_t        ctl;
  lane_res_t        red_res, green_res, blue_res;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign load     = (state_r == ST_DRAIN) && out_free;

  // lane control decode
  always_comb begin
    ctl.clear  = in_acc && (in_kind == KIND_CLEAR);
    ctl.gather = in_acc && (in_kind == KIND_GATHER);
    ctl.start  = in_acc && (in_kind == KIND_MAP);
    ctl.step   = (state_r == ST_DIVIDE);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (ctl.start) begin
          state_nxt = ST_DIVIDE;
          cnt_nxt   = '0;
        end
      end
      ST_DIVIDE: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // channel lanes
  rgbcs_lane u_lane_red (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .pix   (in_red_in),
    .res   (red_res)
  );

  rgbcs_lane u_lane_green (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .pix   (in_green_in),
    .res   (green_res)
  );

  rgbcs_lane u_lane_blue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .pix   (in_blue_in),
    .res   (blue_res)
  );

  // merge and output register
  rgbcs_merge u_merge (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load                (load),
    .red                 (red_res),
    .green               (green_res),
    .blue                (blue_res),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_red_out         (out_red_out),
    .out_green_out       (out_green_out),
    .out_blue_out        (out_blue_out),
    .out_stretch_skipped (out_stretch_skipped)
  );

  // checks
  `RGBCS_ASSERT_NEXT(a_map_blocks_input, clk, rst_n, ctl.start, in_stall)
  `RGBCS_ASSERT_NEXT(a_drain_loads_output, clk, rst_n, load, out_valid && !in_stall)
  `RGBCS_ASSERT_NOW(a_output_from_drain, clk, rst_n, $rose(out_valid), $past(load))

endmodule

>>> rtl/rgbcs_lane.sv
// one colour channel: min/max statistics and a bit-serial stretch divider
module rgbcs_lane import rgbcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  lane_ctl_t        ctl,
  input  logic [PIX_W-1:0] pix,
  output lane_res_t        res
);

  logic [PIX_W-1:0]   min_r, min_nxt;
  logic [PIX_W-1:0]   max_r, max_nxt;
  logic [PIX_W-1:0]   fix_r, fix_nxt;
  logic               div_en_r, div_en_nxt;
  logic               flat_r, flat_nxt;
  logic [PIX_W-1:0]   dsr_r, dsr_nxt;
  logic [PIX_W-1:0]   rem_r, rem_nxt;
  logic [PIX_W-1:0]   nlo_r, nlo_nxt;
  logic [PIX_W-1:0]   quot_r, quot_nxt;
  logic [PIX_W-1:0]   diff;
  logic [2*PIX_W-1:0] num;
  logic [PIX_W:0]     trial;
  logic               qbit;
  logic               flat_now;

  // numerator (v - min) * 255 as a shift and subtract
  assign flat_now = (min_r >= max_r);
  assign diff     = pix - min_r;
  assign num      = {diff, PIX_ZERO} - {PIX_ZERO, diff};

  // one restoring step per cycle
  assign trial = {rem_r, nlo_r[PIX_W-1]};
  assign qbit  = (trial >= {1'b0, dsr_r});

  // statistics update
  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (ctl.clear) begin
      min_nxt = FULL_SCALE;
      max_nxt = PIX_ZERO;
    end else if (ctl.gather) begin
      if (pix < min_r) min_nxt = pix;
      if (pix > max_r) max_nxt = pix;
    end
  end

  // map set-up and divider iteration
  always_comb begin
    fix_nxt    = fix_r;
    div_en_nxt = div_en_r;
    flat_nxt   = flat_r;
    dsr_nxt    = dsr_r;
    rem_nxt    = rem_r;
    nlo_nxt    = nlo_r;
    quot_nxt   = quot_r;
    if (ctl.start) begin
      flat_nxt   = flat_now;
      div_en_nxt = 1'b0;
      dsr_nxt    = max_r - min_r;
      rem_nxt    = num[2*PIX_W-1:PIX_W];
      nlo_nxt    = num[PIX_W-1:0];
      quot_nxt   = PIX_ZERO;
      if (flat_now) begin
        fix_nxt = pix;
      end else if (pix <= min_r) begin
        fix_nxt = PIX_ZERO;
      end else if (pix >= max_r) begin
        fix_nxt = FULL_SCALE;
      end else begin
        fix_nxt    = PIX_ZERO;
        div_en_nxt = 1'b1;
      end
    end else if (ctl.step) begin
      rem_nxt  = qbit ? PIX_W'(trial - {1'b0, dsr_r}) : trial[PIX_W-1:0];
      nlo_nxt  = {nlo_r[PIX_W-2:0], 1'b0};
      quot_nxt = {quot_r[PIX_W-2:0], qbit};
    end
  end

  // statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= FULL_SCALE;
      max_r <= PIX_ZERO;
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    fix_r    <= fix_nxt;
    div_en_r <= div_en_nxt;
    flat_r   <= flat_nxt;
    dsr_r    <= dsr_nxt;
    rem_r    <= rem_nxt;
    nlo_r    <= nlo_nxt;
    quot_r   <= quot_nxt;
  end

  assign res.value = div_en_r ? quot_r : fix_r;
  assign res.flat  = flat_r;

endmodule

>>> rtl/rgbcs_merge.sv
// merges the three lane results into the output request register
module rgbcs_merge import rgbcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  lane_res_t        red,
  input  lane_res_t        green,
  input  lane_res_t        blue,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_red_out,
  output logic [PIX_W-1:0] out_green_out,
  output logic [PIX_W-1:0] out_blue_out,
  output logic             out_stretch_skipped
);

  logic             valid_r, valid_nxt;
  logic [PIX_W-1:0] red_r, green_r, blue_r;
  logic             skip_r;

  // valid holds until the request is taken
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, skip flag when every channel is flat
  always_ff @(posedge clk) begin
    if (load) begin
      red_r   <= red.value;
      green_r <= green.value;
      blue_r  <= blue.value;
      skip_r  <= red.flat & green.flat & blue.flat;
    end
  end

  assign out_valid           = valid_r;
  assign out_red_out         = red_r;
  assign out_green_out       = green_r;
  assign out_blue_out        = blue_r;
  assign out_stretch_skipped = skip_r;

endmodule

>>> dv/tb_top.sv
// self-checking testbench for the rgb min/max contrast stretch block
module tb_top;
  import rgbcs_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int MAX_SHOWN = 10;
  localparam int HOLD_LEN = 300;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             skipped;
  } stretched_pixel_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [KIND_W-1:0] in_kind = KIND_CLEAR;
  logic [PIX_W-1:0]  in_red_in = '0;
  logic [PIX_W-1:0]  in_green_in = '0;
  logic [PIX_W-1:0]  in_blue_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PIX_W-1:0]  out_red_out;
  logic [PIX_W-1:0]  out_green_out;
  logic [PIX_W-1:0]  out_blue_out;
  logic              out_stretch_skipped;

  // statistics as the block should hold them
  logic [PIX_W-1:0] lo_red = FULL_SCALE, lo_green = FULL_SCALE, lo_blue = FULL_SCALE;
  logic [PIX_W-1:0] hi_red = PIX_ZERO, hi_green = PIX_ZERO, hi_blue = PIX_ZERO;

  stretched_pixel_t expected_pixels[$];

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int hold_req_id = 0;
  int hold_seen_id = 0;
  int hold_left = 0;

  int mismatches = 0;
  int results_checked = 0;
  int skipped_seen = 0;
  int clears_sent = 0;
  int gathers_sent = 0;
  int maps_sent = 0;
  int unused_sent = 0;

  rgb_min_max_contrast_stretch_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_red_in           (in_red_in),
    .in_green_in         (in_green_in),
    .in_blue_in          (in_blue_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_red_out         (out_red_out),
    .out_green_out       (out_green_out),
    .out_blue_out        (out_blue_out),
    .out_stretch_skipped (out_stretch_skipped)
  );

  // clock, period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // stretch of one component against its gathered range
  function automatic logic [PIX_W-1:0] stretch_component(input logic [PIX_W-1:0] v,
                                                          input logic [PIX_W-1:0] lo,
                                                          input logic [PIX_W-1:0] hi);
    int q;
    if (lo >= hi) return v;
    q = ((int'(v) - int'(lo)) * 255) / (int'(hi) - int'(lo));
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[PIX_W-1:0];
  endfunction

  // pixel value leaning towards the extremes
  function automatic logic [PIX_W-1:0] rand_pixel();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return PIX_ZERO;
    if (pick < 16) return FULL_SCALE;
    return PIX_W'($urandom_range(255));
  endfunction

  // offer one request, wait for acceptance, then update the predicted state
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [PIX_W-1:0] r,
                              input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
    stretched_pixel_t px;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    do @(posedge clk); while (in_stall);
    case (kind)
      KIND_CLEAR: begin
        lo_red = FULL_SCALE; lo_green = FULL_SCALE; lo_blue = FULL_SCALE;
        hi_red = PIX_ZERO; hi_green = PIX_ZERO; hi_blue = PIX_ZERO;
        clears_sent++;
      end
      KIND_GATHER: begin
        if (r < lo_red) lo_red = r;
        if (g < lo_green) lo_green = g;
        if (b < lo_blue) lo_blue = b;
        if (r > hi_red) hi_red = r;
        if (g > hi_green) hi_green = g;
        if (b > hi_blue) hi_blue = b;
        gathers_sent++;
      end
      KIND_MAP: begin
        px.red     = stretch_component(r, lo_red, hi_red);
        px.green   = stretch_component(g, lo_green, hi_green);
        px.blue    = stretch_component(b, lo_blue, hi_blue);
        px.skipped = (lo_red >= hi_red) && (lo_green >= hi_green) && (lo_blue >= hi_blue);
        expected_pixels.push_back(px);
        maps_sent++;
      end
      default: begin
        unused_sent++;
      end
    endcase
  endtask

  // sender pauses until every expected result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // receiver stall: long hold-off when asked, otherwise random
  always @(posedge clk) begin
    if (hold_req_id != hold_seen_id) begin
      hold_seen_id <= hold_req_id;
      hold_left    <= HOLD_LEN;
      out_stall    <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  task automatic report_field(input string field, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("mismatch on %s: expected %0d, got %0d", field, exp_val, act_val);
    end
  endtask

  // compare each output request with the oldest expectation
  always @(posedge clk) begin
    stretched_pixel_t px;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected output request: %0d %0d %0d skip %0d", out_red_out,
                   out_green_out, out_blue_out, out_stretch_skipped);
      end else begin
        px = expected_pixels.pop_front();
        report_field("red", int'(px.red), int'(out_red_out));
        report_field("green", int'(px.green), int'(out_green_out));
        report_field("blue", int'(px.blue), int'(out_blue_out));
        report_field("stretch_skipped", int'(px.skipped), int'(out_stretch_skipped));
        results_checked++;
        if (out_stretch_skipped) skipped_seen++;
      end
    end
  end

  // maps on empty statistics pass through with the skip flag
  task automatic test_empty_stats();
    send_request(KIND_MAP, 8'd0, 8'd0, 8'd0);
    send_request(KIND_MAP, 8'd255, 8'd255, 8'd255);
    send_request(KIND_MAP, 8'd17, 8'd200, 8'd93);
  endtask

  // full 0..255 range on every channel, then the end points and one inner pixel
  task automatic test_full_range();
    send_request(KIND_CLEAR, 8'd99, 8'd99, 8'd99);
    send_request(KIND_GATHER, 8'd0, 8'd255, 8'd0);
    send_request(KIND_GATHER, 8'd255, 8'd0, 8'd255);
    send_request(KIND_MAP, 8'd0, 8'd0, 8'd0);
    send_request(KIND_MAP, 8'd255, 8'd255, 8'd255);
    send_request(KIND_MAP, 8'd128, 8'd127, 8'd1);
  endtask

  // red and blue constant, green with a span of one
  task automatic test_partial_flat();
    send_request(KIND_CLEAR, 8'd0, 8'd0, 8'd0);
    send_request(KIND_GATHER, 8'd40, 8'd90, 8'd7);
    send_request(KIND_GATHER, 8'd40, 8'd91, 8'd7);
    send_request(KIND_MAP, 8'd40, 8'd91, 8'd200);
    send_request(KIND_MAP, 8'd3, 8'd90, 8'd7);
  endtask

  // components below the minimum and above the maximum clamp, one inside maps
  task automatic test_clamping();
    send_request(KIND_CLEAR, 8'd255, 8'd255, 8'd255);
    send_request(KIND_GATHER, 8'd100, 8'd50, 8'd200);
    send_request(KIND_GATHER, 8'd150, 8'd60, 8'd210);
    send_request(KIND_MAP, 8'd10, 8'd255, 8'd0);
    send_request(KIND_MAP, 8'd255, 8'd0, 8'd255);
    send_request(KIND_MAP, 8'd125, 8'd55, 8'd205);
  endtask

  // the unused kind must leave the statistics alone
  task automatic test_unused_kind();
    send_request(KIND_UNUSED, 8'd255, 8'd255, 8'd255);
    send_request(KIND_UNUSED, 8'd0, 8'd0, 8'd0);
    send_request(KIND_MAP, 8'd120, 8'd57, 8'd201);
  endtask

  // long receiver hold-off while requests keep coming, then a full drain
  task automatic test_backpressure();
    hold_req_id <= hold_req_id + 1;
    for (int i = 0; i < 8; i++) begin
      send_request(KIND_GATHER, rand_pixel(), rand_pixel(), rand_pixel());
      send_request(KIND_MAP, rand_pixel(), rand_pixel(), rand_pixel());
    end
    wait_for_results();
  endtask

  // mostly clear / gather / map sequences with random content, some noise
  task automatic test_random_stream(input int n_items);
    int sent;
    int pick;
    int n_gather;
    int n_map;
    int base;
    int span;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // well-formed frame, often with a narrow range
        base = $urandom_range(255);
        span = ($urandom_range(1)) ? $urandom_range(255 - base) : $urandom_range(4);
        if (base + span > 255) span = 255 - base;
        n_gather = $urandom_range(1, 10);
        n_map = $urandom_range(1, 6);
        send_request(KIND_CLEAR, rand_pixel(), rand_pixel(), rand_pixel());
        for (int i = 0; i < n_gather; i++)
          send_request(KIND_GATHER, PIX_W'(base + $urandom_range(span)),
                       PIX_W'(base + $urandom_range(span)), rand_pixel());
        for (int i = 0; i < n_map; i++)
          send_request(KIND_MAP, rand_pixel(), rand_pixel(), rand_pixel());
        sent += 1 + n_gather + n_map;
      end else if (pick < 82) begin
        // one channel held constant over the frame
        base = $urandom_range(255);
        n_gather = $urandom_range(1, 5);
        send_request(KIND_CLEAR, rand_pixel(), rand_pixel(), rand_pixel());
        for (int i = 0; i < n_gather; i++)
          send_request(KIND_GATHER, rand_pixel(), PIX_W'(base), rand_pixel());
        send_request(KIND_MAP, rand_pixel(), rand_pixel(), rand_pixel());
        sent += 2 + n_gather;
      end else if (pick < 92) begin
        // maps on whatever statistics are held
        n_map = $urandom_range(1, 4);
        for (int i = 0; i < n_map; i++)
          send_request(KIND_MAP, rand_pixel(), rand_pixel(), rand_pixel());
        sent += n_map;
      end else begin
        // noise: any kind, the unused one included
        n_gather = $urandom_range(1, 4);
        for (int i = 0; i < n_gather; i++) begin
          pick = $urandom_range(3);
          send_request(KIND_W'(pick), rand_pixel(), rand_pixel(), rand_pixel());
          if (KIND_W'(pick) != KIND_UNUSED) sent++;
        end
      end
    end
  endtask

  // main sequence
  initial begin
    int guard;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stats();
    test_full_range();
    test_partial_flat();
    test_clamping();
    test_unused_kind();
    test_backpressure();

    sender_idle_pct = 16;
    receiver_idle_pct = 61;
    test_random_stream(220);
    sender_idle_pct = 61;
    receiver_idle_pct = 16;
    test_random_stream(220);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_random_stream(210);

    in_valid <= 1'b0;
    guard = 0;
    while (expected_pixels.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      mismatches++;
      $display("%0d expected output requests never arrived", expected_pixels.size());
    end

    $display("sent %0d clears, %0d gathers, %0d maps, %0d unused-kind requests",
             clears_sent, gathers_sent, maps_sent, unused_sent);
    $display("checked %0d outputs (%0d skipped), %0d mismatches", results_checked,
             skipped_seen, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("timeout: run did not complete");
    $display("Regression FAIL");
    $finish;
  end

endmodule
